[sv/tpswc_pkg.sv]
// Shared constants, types and controller codes for the tile plane scroll core.
`timescale 1ns / 1ps
package tpswc_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_TILES_DEF = 4096;
  localparam int FRAC_BITS_DEF = 12;
  localparam int MAX_VIEW_DEF  = 256;

  // Fixed field widths of the request and result channels.
  localparam int COORD_W   = 32;
  localparam int MODE_W    = 2;
  localparam int TILES_W   = 13;
  localparam int VIEW_W    = 9;
  localparam int ANCHOR_W  = 12;
  localparam int WRAPPED_W = 24;
  localparam int TILE_W    = 12;
  localparam int ORIGIN_W  = 14;

  // The remainder is built one dividend bit per cycle.
  localparam int DIV_STEPS = COORD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam int MODE_WRAP_X = 0;
  localparam int MODE_WRAP_Y = 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_SEL  = 5'b00100,
    ST_ORG  = 5'b01000,
    ST_EXT  = 5'b10000
  } state_t;

  // Commands from the controller to both axis lanes.
  typedef struct packed {
    logic load;  // capture a request
    logic step;  // one restoring-division step
    logic sel;   // pick the corrected coordinate
    logic org;   // form the origin
    logic emit;  // load the result register
  } cmd_t;

endpackage

[sv/tpswc_req_if.sv]
// Request channel: valid/ready handshake with the scroll request payload.
`timescale 1ns / 1ps
interface tpswc_req_if
  import tpswc_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  coord_x;
  logic signed [COORD_W-1:0]  coord_y;
  logic        [MODE_W-1:0]   wrap_mode;
  logic        [TILES_W-1:0]  tiles_wide;
  logic        [TILES_W-1:0]  tiles_high;
  logic        [VIEW_W-1:0]   view_w;
  logic        [VIEW_W-1:0]   view_h;
  logic        [ANCHOR_W-1:0] anchor_x;
  logic        [ANCHOR_W-1:0] anchor_y;

  modport source (
    output valid, coord_x, coord_y, wrap_mode, tiles_wide, tiles_high,
           view_w, view_h, anchor_x, anchor_y,
    input  ready
  );
  modport sink (
    input  valid, coord_x, coord_y, wrap_mode, tiles_wide, tiles_high,
           view_w, view_h, anchor_x, anchor_y,
    output ready
  );
endinterface

[sv/tpswc_res_if.sv]
// Result channel: valid/ready handshake with the corrected position payload.
`timescale 1ns / 1ps
interface tpswc_res_if
  import tpswc_pkg::*;
;
  logic                        valid;
  logic                        ready;
  logic        [WRAPPED_W-1:0] wrapped_x;
  logic        [WRAPPED_W-1:0] wrapped_y;
  logic        [TILE_W-1:0]    tile_x;
  logic        [TILE_W-1:0]    tile_y;
  logic signed [ORIGIN_W-1:0]  origin_x;
  logic signed [ORIGIN_W-1:0]  origin_y;
  logic signed [ORIGIN_W-1:0]  extent_x;
  logic signed [ORIGIN_W-1:0]  extent_y;

  modport source (
    output valid, wrapped_x, wrapped_y, tile_x, tile_y, origin_x, origin_y,
           extent_x, extent_y,
    input  ready
  );
  modport sink (
    input  valid, wrapped_x, wrapped_y, tile_x, tile_y, origin_x, origin_y,
           extent_x, extent_y,
    output ready
  );
endinterface

[sv/tpswc_axis.sv]
// One axis lane: serial modulo, wrap or clamp, origin and extent correction.
`timescale 1ns / 1ps
module tpswc_axis
  import tpswc_pkg::*;
#(
  parameter int MAX_TILES = MAX_TILES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_VIEW  = MAX_VIEW_DEF
) (
  input  logic                       clk,
  input  cmd_t                       cmd,
  input  logic signed [COORD_W-1:0]  coord,
  input  logic                       wrap,
  input  logic        [TILES_W-1:0]  tiles,
  input  logic        [VIEW_W-1:0]   view,
  input  logic        [ANCHOR_W-1:0] anchor,
  output logic        [WRAPPED_W-1:0] wrapped,
  output logic        [TILE_W-1:0]    tile,
  output logic signed [ORIGIN_W-1:0]  origin,
  output logic signed [ORIGIN_W-1:0]  extent
);

  localparam int CW   = $clog2(MAX_TILES + 1);
  localparam int VCW  = $clog2(MAX_VIEW + 1);
  localparam int MW   = CW + FRAC_BITS;
  localparam int CMPW = (MW > COORD_W - 1) ? MW : COORD_W - 1;
  localparam int WXW  = (MW > WRAPPED_W) ? MW : WRAPPED_W;
  localparam int TXW  = (CW > TILE_W) ? CW : TILE_W;
  localparam int BW0  = (CW > ANCHOR_W) ? CW : ANCHOR_W;
  localparam int BW1  = (BW0 > VCW) ? BW0 : VCW;
  localparam int BW2  = BW1 + 3;
  localparam int OW   = (BW2 > ORIGIN_W + 1) ? BW2 : ORIGIN_W + 1;

  logic        [COORD_W-1:0]  mag;
  logic        [COORD_W-1:0]  coord_r;
  logic                       neg;
  logic                       wrap_r;
  logic        [CW-1:0]       count;
  logic        [VCW-1:0]      view_r;
  logic        [ANCHOR_W-1:0] anchor_r;
  logic        [MW-1:0]       rem;
  logic        [MW-1:0]       v;
  logic signed [OW-1:0]       org;

  logic        [31:0]         tiles_ext;
  logic        [31:0]         view_ext;
  logic        [CW-1:0]       count_sat;
  logic        [VCW-1:0]      view_sat;
  logic        [MW-1:0]       m;
  logic        [MW:0]         rem_sh;
  logic        [MW:0]         rem_diff;
  logic        [MW-1:0]       rem_next;
  logic        [MW-1:0]       v_next;
  logic        [CW-1:0]       count_m1;
  logic        [CMPW-1:0]     coord_pos;
  logic        [CW-1:0]       tile_full;
  logic signed [OW-1:0]       org_raw;
  logic signed [OW-1:0]       org_next;
  logic signed [OW-1:0]       cnt_s;
  logic signed [OW-1:0]       ext_raw;
  logic signed [OW-1:0]       org_fin;
  logic signed [OW-1:0]       ext_fin;
  logic        [WXW-1:0]      v_wide;
  logic        [TXW-1:0]      tile_wide;

  // Saturate the plane and view sizes into their legal ranges.
  always_comb begin
    tiles_ext = 32'(tiles);
    view_ext  = 32'(view);
    if (tiles_ext == 32'd0) begin
      count_sat = CW'(1);
    end else if (tiles_ext > 32'(MAX_TILES)) begin
      count_sat = CW'(MAX_TILES);
    end else begin
      count_sat = tiles_ext[CW-1:0];
    end
    if (view_ext == 32'd0) begin
      view_sat = VCW'(1);
    end else if (view_ext > 32'(MAX_VIEW)) begin
      view_sat = VCW'(MAX_VIEW);
    end else begin
      view_sat = view_ext[VCW-1:0];
    end
  end

  assign m = {count, {FRAC_BITS{1'b0}}};

  // Restoring division step on the coordinate magnitude.
  always_comb begin
    rem_sh   = {rem, mag[COORD_W-1]};
    rem_diff = rem_sh - {1'b0, m};
    if (rem_sh >= {1'b0, m}) begin
      rem_next = rem_diff[MW-1:0];
    end else begin
      rem_next = rem_sh[MW-1:0];
    end
  end

  // Corrected coordinate: floored modulo when wrapping, otherwise a clamp.
  always_comb begin
    count_m1  = count - CW'(1);
    coord_pos = CMPW'(coord_r[COORD_W-2:0]);
    if (wrap_r) begin
      if (neg && (rem != '0)) begin
        v_next = m - rem;
      end else begin
        v_next = rem;
      end
    end else if (coord_r[COORD_W-1]) begin
      v_next = '0;
    end else if (coord_pos >= CMPW'(m)) begin
      v_next = {count_m1, {FRAC_BITS{1'b0}}};
    end else begin
      v_next = coord_pos[MW-1:0];
    end
  end

  assign tile_full = v[MW-1:FRAC_BITS];
  assign cnt_s     = OW'(count);

  // A negative origin wraps once by the count, or clamps to zero.
  always_comb begin
    org_raw = OW'(tile_full) - OW'(anchor_r);
    if (org_raw < 0) begin
      org_next = wrap_r ? (cnt_s + org_raw) : '0;
    end else begin
      org_next = org_raw;
    end
  end

  // An overrun past the plane end on a clamped axis pulls the window back.
  always_comb begin
    ext_raw = OW'(view_r) + org - OW'(1);
    if (!wrap_r && (ext_raw >= cnt_s)) begin
      ext_fin = cnt_s - OW'(1);
      org_fin = cnt_s - OW'(view_r);
    end else begin
      ext_fin = ext_raw;
      org_fin = org;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg      <= coord[COORD_W-1];
      mag      <= coord[COORD_W-1] ? (COORD_W'(0) - coord) : coord;
      coord_r  <= coord;
      wrap_r   <= wrap;
      count    <= count_sat;
      view_r   <= view_sat;
      anchor_r <= anchor;
      rem      <= '0;
    end else if (cmd.step) begin
      rem <= rem_next;
      mag <= {mag[COORD_W-2:0], 1'b0};
    end
    if (cmd.sel) begin
      v <= v_next;
    end
    if (cmd.org) begin
      org <= org_next;
    end
  end

  assign v_wide    = WXW'(v);
  assign tile_wide = TXW'(tile_full);
  assign wrapped   = v_wide[WRAPPED_W-1:0];
  assign tile      = tile_wide[TILE_W-1:0];
  assign origin    = org_fin[ORIGIN_W-1:0];
  assign extent    = ext_fin[ORIGIN_W-1:0];

endmodule

[sv/tpswc_dp.sv]
// Datapath: the X and Y axis lanes and the result register.
`timescale 1ns / 1ps
module tpswc_dp
  import tpswc_pkg::*;
#(
  parameter int MAX_TILES = MAX_TILES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_VIEW  = MAX_VIEW_DEF
) (
  input  logic                        clk,
  input  cmd_t                        cmd,
  input  logic signed [COORD_W-1:0]   coord_x,
  input  logic signed [COORD_W-1:0]   coord_y,
  input  logic        [MODE_W-1:0]    wrap_mode,
  input  logic        [TILES_W-1:0]   tiles_wide,
  input  logic        [TILES_W-1:0]   tiles_high,
  input  logic        [VIEW_W-1:0]    view_w,
  input  logic        [VIEW_W-1:0]    view_h,
  input  logic        [ANCHOR_W-1:0]  anchor_x,
  input  logic        [ANCHOR_W-1:0]  anchor_y,
  output logic        [WRAPPED_W-1:0] wrapped_x,
  output logic        [WRAPPED_W-1:0] wrapped_y,
  output logic        [TILE_W-1:0]    tile_x,
  output logic        [TILE_W-1:0]    tile_y,
  output logic signed [ORIGIN_W-1:0]  origin_x,
  output logic signed [ORIGIN_W-1:0]  origin_y,
  output logic signed [ORIGIN_W-1:0]  extent_x,
  output logic signed [ORIGIN_W-1:0]  extent_y
);

  logic        [WRAPPED_W-1:0] lane_wrapped_x;
  logic        [WRAPPED_W-1:0] lane_wrapped_y;
  logic        [TILE_W-1:0]    lane_tile_x;
  logic        [TILE_W-1:0]    lane_tile_y;
  logic signed [ORIGIN_W-1:0]  lane_origin_x;
  logic signed [ORIGIN_W-1:0]  lane_origin_y;
  logic signed [ORIGIN_W-1:0]  lane_extent_x;
  logic signed [ORIGIN_W-1:0]  lane_extent_y;

  tpswc_axis #(
    .MAX_TILES (MAX_TILES),
    .FRAC_BITS (FRAC_BITS),
    .MAX_VIEW  (MAX_VIEW)
  ) u_axis_x (
    .clk     (clk),
    .cmd     (cmd),
    .coord   (coord_x),
    .wrap    (wrap_mode[MODE_WRAP_X]),
    .tiles   (tiles_wide),
    .view    (view_w),
    .anchor  (anchor_x),
    .wrapped (lane_wrapped_x),
    .tile    (lane_tile_x),
    .origin  (lane_origin_x),
    .extent  (lane_extent_x)
  );

  tpswc_axis #(
    .MAX_TILES (MAX_TILES),
    .FRAC_BITS (FRAC_BITS),
    .MAX_VIEW  (MAX_VIEW)
  ) u_axis_y (
    .clk     (clk),
    .cmd     (cmd),
    .coord   (coord_y),
    .wrap    (wrap_mode[MODE_WRAP_Y]),
    .tiles   (tiles_high),
    .view    (view_h),
    .anchor  (anchor_y),
    .wrapped (lane_wrapped_y),
    .tile    (lane_tile_y),
    .origin  (lane_origin_y),
    .extent  (lane_extent_y)
  );

  // The result register holds a finished item until the transfer completes.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      wrapped_x <= lane_wrapped_x;
      wrapped_y <= lane_wrapped_y;
      tile_x    <= lane_tile_x;
      tile_y    <= lane_tile_y;
      origin_x  <= lane_origin_x;
      origin_y  <= lane_origin_y;
      extent_x  <= lane_extent_x;
      extent_y  <= lane_extent_y;
    end
  end

endmodule

[sv/tpswc_ctrl.sv]
// Controller: sequences capture, division steps, correction and result hand-off.
`timescale 1ns / 1ps
module tpswc_ctrl
  import tpswc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid,
  output cmd_t cmd
);

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  cnt;
  logic              out_valid_next;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    in_ready       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_SEL;
        end
      end
      ST_SEL: begin
        cmd.sel    = 1'b1;
        state_next = ST_ORG;
      end
      ST_ORG: begin
        cmd.org    = 1'b1;
        state_next = ST_EXT;
      end
      ST_EXT: begin
        // Wait here while the previous result is still unclaimed.
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (cmd.load) begin
        cnt <= '0;
      end else if (cmd.step) begin
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

endmodule

[sv/tile_plane_scroll_wrap_clamp_core.sv]
// Top level of the tile plane scroll correction core.
//
// A request on req carries signed Q20.12 X and Y scroll positions, per-axis
// wrap bits, the plane size, the viewport size and the view anchor. Each
// request gives exactly one result on res: the corrected coordinates, their
// integer tiles and the first and last visible tile on each axis.
// Requests are taken only when the core is idle. Both axes run side by side;
// the wrap modulo is a restoring division that takes one coordinate bit per
// cycle, followed by the select, origin and extent correction states. The
// core returns to idle, and takes a new request, only once the result of the
// previous one has been loaded into the output register. The result sits in
// that output register: if the receiver stalls, the core still accepts and
// works on the next request, and holds it finished until the waiting result
// has been transferred.
// Reset (rst, synchronous) returns the controller to idle and empties the
// result register; no state is kept between requests.
`timescale 1ns / 1ps
module tile_plane_scroll_wrap_clamp_core
  import tpswc_pkg::*;
#(
  parameter int MAX_TILES = MAX_TILES_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MAX_VIEW  = MAX_VIEW_DEF
) (
  input logic  clk,
  input logic  rst,
  tpswc_req_if.sink   req,
  tpswc_res_if.source res
);

  cmd_t cmd;

  tpswc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_ready (res.ready),
    .out_valid (res.valid),
    .cmd       (cmd)
  );

  tpswc_dp #(
    .MAX_TILES (MAX_TILES),
    .FRAC_BITS (FRAC_BITS),
    .MAX_VIEW  (MAX_VIEW)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .coord_x    (req.coord_x),
    .coord_y    (req.coord_y),
    .wrap_mode  (req.wrap_mode),
    .tiles_wide (req.tiles_wide),
    .tiles_high (req.tiles_high),
    .view_w     (req.view_w),
    .view_h     (req.view_h),
    .anchor_x   (req.anchor_x),
    .anchor_y   (req.anchor_y),
    .wrapped_x  (res.wrapped_x),
    .wrapped_y  (res.wrapped_y),
    .tile_x     (res.tile_x),
    .tile_y     (res.tile_y),
    .origin_x   (res.origin_x),
    .origin_y   (res.origin_y),
    .extent_x   (res.extent_x),
    .extent_y   (res.extent_y)
  );

endmodule
